// ----- rtl/core/assert_macros.svh -----
// Assertion helpers shared by the core RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// prop must hold at every clock edge outside reset
`define ASSERT_PROP(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) else $error(msg);

// cond must never be seen outside reset
`define ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
    `ASSERT_PROP(lbl, clk, rst_n, !(cond), msg)

`else

`define ASSERT_PROP(lbl, clk, rst_n, prop, msg)
`define ASSERT_NEVER(lbl, clk, rst_n, cond, msg)

`endif

`endif

// ----- rtl/core/bra_pkg.sv -----
package bra_pkg;

    localparam int MAX_SENSORS      = 8;
    localparam int SENSOR_COUNT_DEF = 8;
    localparam int PAIR_MAX         = 4;
    localparam int DIST_W           = 16;
    localparam int WEIGHT_W         = 15;
    localparam int DSUM_W           = DIST_W + 3;
    localparam int ACC_W            = 34;
    localparam int MAG_W            = ACC_W - 1;
    localparam int QUO_W            = 16;
    localparam int ANGLE_W          = 16;
    localparam int CFG_IDX_W        = 3;
    localparam int CFG_DATA_W       = 16;
    localparam int QUEUE_DEPTH      = 4;

    localparam logic [ANGLE_W-1:0] ANGLE_MAX = 16'h7FFF;
    localparam logic [ANGLE_W-1:0] ANGLE_MIN = 16'h8000;

    localparam logic [DIST_W-1:0]   BOUNDARY_RST     = 16'd2458;
    localparam logic [WEIGHT_W-1:0] WEIGHT_OUTER_RST  = 15'd25736;
    localparam logic [WEIGHT_W-1:0] WEIGHT_SECOND_RST = 15'd14298;
    localparam logic [WEIGHT_W-1:0] WEIGHT_THIRD_RST  = 15'd8579;
    localparam logic [WEIGHT_W-1:0] WEIGHT_INNER_RST  = 15'd2860;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_BOUNDARY  = 3'd0,
        REG_W_OUTER   = 3'd1,
        REG_W_SECOND  = 3'd2,
        REG_W_THIRD   = 3'd3,
        REG_W_INNER   = 3'd4
    } t_reg_idx;

    typedef logic [MAX_SENSORS-1:0][DIST_W-1:0] t_dist_vec;

    typedef struct packed {
        logic [DIST_W-1:0]                 boundary;
        logic [PAIR_MAX-1:0][WEIGHT_W-1:0] weight;
    } t_cfg;

    // one classified frame, ready for the divide
    typedef struct packed {
        logic              seen;
        logic              zero;
        logic              neg;
        logic [MAG_W-1:0]  mag;
        logic [DSUM_W-1:0] dsum;
    } t_job;

    typedef struct packed {
        logic full;
        logic nonempty;
    } t_q_stat;

endpackage

// ----- rtl/core/bubble_rebound_angle_top.sv -----
// Channel   Handshake                   Payload
// in        i_in_valid / o_in_ready     i_distance_0 .. i_distance_7
// out       o_out_valid / i_out_ready   o_rebound_angle, o_obstacle_seen, o_sum_zero
// cfg       i_cfg_we                    i_cfg_index, i_cfg_data
//
// One beat per cycle in and out when unstalled; the divide is fully pipelined, one quotient bit per stage.
// Stages: 2 front stages, 1 queue slot, 17 divide stages, 1 output register.
// Reset is synchronous, active low; it clears valid bits and queue pointers and
// loads the config defaults.
// A stall on the output freezes the divide pipeline; the front keeps filling
// the 4-beat queue and stops taking beats only when it is full.
module bubble_rebound_angle_top #(
    parameter int SENSOR_COUNT = bra_pkg::SENSOR_COUNT_DEF
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_in_valid,
    output logic                                 o_in_ready,
    input  logic [bra_pkg::DIST_W-1:0]           i_distance_0,
    input  logic [bra_pkg::DIST_W-1:0]           i_distance_1,
    input  logic [bra_pkg::DIST_W-1:0]           i_distance_2,
    input  logic [bra_pkg::DIST_W-1:0]           i_distance_3,
    input  logic [bra_pkg::DIST_W-1:0]           i_distance_4,
    input  logic [bra_pkg::DIST_W-1:0]           i_distance_5,
    input  logic [bra_pkg::DIST_W-1:0]           i_distance_6,
    input  logic [bra_pkg::DIST_W-1:0]           i_distance_7,
    output logic                                 o_out_valid,
    input  logic                                 i_out_ready,
    output logic signed [bra_pkg::ANGLE_W-1:0]   o_rebound_angle,
    output logic                                 o_obstacle_seen,
    output logic                                 o_sum_zero,
    input  logic                                 i_cfg_we,
    input  logic [bra_pkg::CFG_IDX_W-1:0]        i_cfg_index,
    input  logic [bra_pkg::CFG_DATA_W-1:0]       i_cfg_data
);
    import bra_pkg::*;

    t_cfg      r_cfg;
    t_dist_vec dist_vec;
    logic      push;
    logic      pop;
    t_job      front_job;
    t_job      queue_job;
    t_q_stat   q_stat;

    assign dist_vec = {i_distance_7, i_distance_6, i_distance_5, i_distance_4,
                       i_distance_3, i_distance_2, i_distance_1, i_distance_0};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.boundary  <= BOUNDARY_RST;
            r_cfg.weight[0] <= WEIGHT_OUTER_RST;
            r_cfg.weight[1] <= WEIGHT_SECOND_RST;
            r_cfg.weight[2] <= WEIGHT_THIRD_RST;
            r_cfg.weight[3] <= WEIGHT_INNER_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_BOUNDARY: r_cfg.boundary  <= i_cfg_data;
                REG_W_OUTER:  r_cfg.weight[0] <= i_cfg_data[WEIGHT_W-1:0];
                REG_W_SECOND: r_cfg.weight[1] <= i_cfg_data[WEIGHT_W-1:0];
                REG_W_THIRD:  r_cfg.weight[2] <= i_cfg_data[WEIGHT_W-1:0];
                REG_W_INNER:  r_cfg.weight[3] <= i_cfg_data[WEIGHT_W-1:0];
                default:      r_cfg <= r_cfg;
            endcase
        end
    end

    bra_front #(
        .SENSOR_COUNT (SENSOR_COUNT)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (r_cfg),
        .i_valid (i_in_valid),
        .o_ready (o_in_ready),
        .i_dist  (dist_vec),
        .o_push  (push),
        .o_job   (front_job),
        .i_stat  (q_stat)
    );

    bra_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (front_job),
        .i_pop   (pop),
        .o_job   (queue_job),
        .o_stat  (q_stat)
    );

    bra_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_stat  (q_stat),
        .i_job   (queue_job),
        .o_pop   (pop),
        .o_valid (o_out_valid),
        .i_ready (i_out_ready),
        .o_angle (o_rebound_angle),
        .o_seen  (o_obstacle_seen),
        .o_zero  (o_sum_zero)
    );

endmodule

// ----- rtl/core/bra_front.sv -----
module bra_front #(
    parameter int SENSOR_COUNT = bra_pkg::SENSOR_COUNT_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  bra_pkg::t_cfg      i_cfg,
    input  logic               i_valid,
    output logic               o_ready,
    input  bra_pkg::t_dist_vec i_dist,
    output logic               o_push,
    output bra_pkg::t_job      o_job,
    input  bra_pkg::t_q_stat   i_stat
);
    import bra_pkg::*;

    localparam int PAIRS = SENSOR_COUNT / 2;

    logic                    en;
    logic                    n_seen;
    logic [DSUM_W-1:0]       n_dsum;
    logic signed [ACC_W-1:0] n_prod [PAIR_MAX];

    logic                    r_a_valid;
    logic                    r_a_seen;
    logic [DSUM_W-1:0]       r_a_dsum;
    logic signed [ACC_W-1:0] r_a_prod [PAIR_MAX];

    logic signed [ACC_W-1:0] acc;
    t_job                    n_job;
    logic                    r_b_valid;
    t_job                    r_b_job;

    // whole front moves together; holds only when its last stage cannot drain
    assign en      = !r_b_valid || !i_stat.full;
    assign o_ready = en;
    assign o_push  = r_b_valid && !i_stat.full;
    assign o_job   = r_b_job;

    always_comb begin
        n_seen = 1'b0;
        n_dsum = '0;
        for (int i = 0; i < MAX_SENSORS; i++) begin
            if (i < SENSOR_COUNT) begin
                if (i_dist[i] <= i_cfg.boundary) begin
                    n_seen = 1'b1;
                end
                n_dsum = n_dsum + DSUM_W'(i_dist[i]);
            end
        end
    end

    for (genvar p = 0; p < PAIR_MAX; p++) begin : g_pair
        if (p < PAIRS) begin : g_used
            logic signed [DIST_W:0] diff;
            logic signed [DIST_W:0] wext;
            assign diff = $signed({1'b0, i_dist[p]})
                        - $signed({1'b0, i_dist[SENSOR_COUNT-1-p]});
            assign wext = $signed({{(DIST_W + 1 - WEIGHT_W){1'b0}}, i_cfg.weight[p]});
            assign n_prod[p] = ACC_W'(wext) * ACC_W'(diff);
        end else begin : g_unused
            assign n_prod[p] = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
        end else if (en) begin
            r_a_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_a_seen <= n_seen;
            r_a_dsum <= n_dsum;
            for (int p = 0; p < PAIR_MAX; p++) begin
                r_a_prod[p] <= n_prod[p];
            end
        end
    end

    always_comb begin
        acc = r_a_prod[0] + r_a_prod[1] + r_a_prod[2] + r_a_prod[3];
        n_job.seen = r_a_seen;
        n_job.zero = r_a_seen && (r_a_dsum == '0);
        n_job.neg  = acc[ACC_W-1];
        n_job.mag  = acc[ACC_W-1] ? MAG_W'(-acc) : MAG_W'(acc);
        n_job.dsum = r_a_dsum;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_valid <= 1'b0;
        end else if (en) begin
            r_b_valid <= r_a_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_b_job <= n_job;
        end
    end

endmodule

// ----- rtl/core/bra_queue.sv -----
`include "assert_macros.svh"

module bra_queue (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  bra_pkg::t_job    i_job,
    input  logic             i_pop,
    output bra_pkg::t_job    o_job,
    output bra_pkg::t_q_stat o_stat
);
    import bra_pkg::*;

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(QUEUE_DEPTH);

    t_job             r_mem [QUEUE_DEPTH];
    logic [PTR_W-1:0] r_wr;
    logic [PTR_W-1:0] r_rd;
    logic [CNT_W-1:0] r_count;
    logic             do_push;
    logic             do_pop;

    assign do_push         = i_push && (r_count != CNT_FULL);
    assign do_pop          = i_pop && (r_count != '0);
    assign o_stat.full     = (r_count == CNT_FULL);
    assign o_stat.nonempty = (r_count != '0);
    assign o_job           = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (do_push) begin
                r_wr <= r_wr + PTR_W'(1);
            end
            if (do_pop) begin
                r_rd <= r_rd + PTR_W'(1);
            end
            case ({do_push, do_pop})
                2'b10:   r_count <= r_count + CNT_W'(1);
                2'b01:   r_count <= r_count - CNT_W'(1);
                default: r_count <= r_count;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_job;
        end
    end

    `ASSERT_NEVER(a_no_overflow, i_clk, i_rst_n, i_push && o_stat.full, "push into full queue")
    `ASSERT_NEVER(a_no_underflow, i_clk, i_rst_n, i_pop && !o_stat.nonempty, "pop from empty queue")
    `ASSERT_PROP(a_count_up, i_clk, i_rst_n, (do_push && !do_pop) |=> (r_count == $past(r_count) + CNT_W'(1)), "count missed a push")
    `ASSERT_PROP(a_ptr_gap, i_clk, i_rst_n, (r_count == '0) || (r_count == CNT_FULL) || (r_wr != r_rd), "pointers disagree with count")

endmodule

// ----- rtl/core/bra_back.sv -----
module bra_back (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  bra_pkg::t_q_stat              i_stat,
    input  bra_pkg::t_job                 i_job,
    output logic                          o_pop,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic signed [bra_pkg::ANGLE_W-1:0] o_angle,
    output logic                          o_seen,
    output logic                          o_zero
);
    import bra_pkg::*;

    localparam int REM_W = MAG_W + 1;

    logic             en;
    logic             r_v   [QUO_W+1];
    t_job             r_job [QUO_W+1];
    logic [MAG_W-1:0] r_rem [QUO_W+1];
    logic [QUO_W-1:0] r_q   [QUO_W+1];

    logic [ANGLE_W-1:0] n_angle;
    logic               r_o_valid;
    logic [ANGLE_W-1:0] r_o_angle;
    logic               r_o_seen;
    logic               r_o_zero;

    assign en      = !r_o_valid || i_ready;
    assign o_pop   = en && i_stat.nonempty;
    assign o_valid = r_o_valid;
    assign o_angle = $signed(r_o_angle);
    assign o_seen  = r_o_seen;
    assign o_zero  = r_o_zero;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v[0] <= 1'b0;
        end else if (en) begin
            r_v[0] <= i_stat.nonempty;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_job[0] <= i_job;
            r_rem[0] <= i_job.mag;
            r_q[0]   <= '0;
        end
    end

    // restoring divide, one quotient bit per stage, msb first
    for (genvar s = 1; s <= QUO_W; s++) begin : g_div
        localparam int K = QUO_W - s;
        logic [REM_W-1:0] trial;
        logic             ge;
        logic [REM_W-1:0] diff;

        assign trial = REM_W'(r_job[s-1].dsum) << K;
        assign ge    = {1'b0, r_rem[s-1]} >= trial;
        assign diff  = {1'b0, r_rem[s-1]} - trial;

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[s] <= 1'b0;
            end else if (en) begin
                r_v[s] <= r_v[s-1];
            end
        end

        always_ff @(posedge i_clk) begin
            if (en) begin
                r_job[s] <= r_job[s-1];
                r_rem[s] <= ge ? diff[MAG_W-1:0] : r_rem[s-1];
                r_q[s]   <= r_q[s-1] | (ge ? (QUO_W'(1) << K) : '0);
            end
        end
    end

    always_comb begin
        if (!r_job[QUO_W].seen || r_job[QUO_W].zero) begin
            n_angle = '0;
        end else if (!r_job[QUO_W].neg) begin
            n_angle = (r_q[QUO_W] > ANGLE_MAX) ? ANGLE_MAX : r_q[QUO_W];
        end else begin
            n_angle = (r_q[QUO_W] > ANGLE_MIN) ? ANGLE_MIN : (~r_q[QUO_W] + QUO_W'(1));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (en) begin
            r_o_valid <= r_v[QUO_W];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_o_angle <= n_angle;
            r_o_seen  <= r_job[QUO_W].seen;
            r_o_zero  <= r_job[QUO_W].zero;
        end
    end

endmodule
